### hw/rtl/plinorm_pkg.sv
// Shared types and constants for the piecewise linear inverse normal block.
// Used by every module under hw/rtl; depends on nothing else.
package plinorm_pkg;

  // Number of segments in the coefficient table.
  localparam int TABLE_ENTRIES = 16;
  localparam int SEG_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 40;

  localparam logic signed [31:0] DEV_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DEV_MIN = 32'sh8000_0000;

  // Item kinds carried on in_tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [31:0]        sample;
    logic [3:0]         entry_index;
    logic signed [31:0] intercept;
    logic signed [63:0] slope;
    logic               last;
  } in_item_t;

  // Reflected sample with the coefficients of its segment.
  typedef struct packed {
    logic [31:0]        u;
    logic               neg;
    logic [SEG_W-1:0]   seg;
    logic signed [31:0] intercept;
    logic signed [63:0] slope;
    logic               last;
  } sel_t;

  // Partial products of slope * u, ready to be summed.
  typedef struct packed {
    logic signed [63:0] p_hi;
    logic [31:0]        lo_top;
    logic signed [31:0] intercept;
    logic               neg;
    logic [SEG_W-1:0]   seg;
    logic               last;
  } prod_t;

endpackage

### hw/rtl/plinorm_front.sv
// Input register, coefficient table, reflection and segment selection.
// Depends on plinorm_pkg.
module plinorm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  plinorm_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plinorm_pkg::sel_t    out_sel
);

  logic                  s1_v_r;
  plinorm_pkg::in_item_t s1_r;

  logic signed [31:0] icpt_tab_r  [plinorm_pkg::TABLE_ENTRIES];
  logic signed [63:0] slope_tab_r [plinorm_pkg::TABLE_ENTRIES];

  logic                          wr_en;
  logic [plinorm_pkg::SEG_W-1:0] wr_addr;
  logic                          neg;
  logic [31:0]                   u_ref;
  logic [plinorm_pkg::SEG_W-1:0] seg;

  // Leading-zero count, limited to the last table entry. A zero input
  // counts as 32 and is limited too.
  function automatic logic [plinorm_pkg::SEG_W-1:0] seg_of(input logic [31:0] v);
    int n;
    n = 32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 31 - i;
      end
    end
    if (n > plinorm_pkg::TABLE_ENTRIES - 1) begin
      n = plinorm_pkg::TABLE_ENTRIES - 1;
    end
    return plinorm_pkg::SEG_W'(n);
  endfunction

  // A write item leaves the input register at once; a sample waits for the multiplier.
  assign in_ready  = !s1_v_r || (s1_r.action == plinorm_pkg::ACT_WRITE) || out_ready;
  assign out_valid = s1_v_r && (s1_r.action == plinorm_pkg::ACT_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_r <= in_item;
    end
  end

  // Writes are done from the input register, so a sample sees exactly
  // the writes that were accepted before it.
  assign wr_en   = s1_v_r && (s1_r.action == plinorm_pkg::ACT_WRITE) &&
                   (32'(s1_r.entry_index) < 32'(plinorm_pkg::TABLE_ENTRIES));
  assign wr_addr = plinorm_pkg::SEG_W'(s1_r.entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      icpt_tab_r[wr_addr]  <= s1_r.intercept;
      slope_tab_r[wr_addr] <= s1_r.slope;
    end
  end

  // One half and above fold to 1-u; one half itself stays one half.
  assign neg   = s1_r.sample[31];
  assign u_ref = neg ? (32'd0 - s1_r.sample) : s1_r.sample;
  assign seg   = seg_of(u_ref);

  always_comb begin
    out_sel.u         = u_ref;
    out_sel.neg       = neg;
    out_sel.seg       = seg;
    out_sel.intercept = icpt_tab_r[seg];
    out_sel.slope     = slope_tab_r[seg];
    out_sel.last      = s1_r.last;
  end

  // Segment zero is chosen exactly when the folded sample has its top bit set.
  a_seg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((seg == '0) == u_ref[31]))
    else $error("segment selection does not match the folded sample");

endmodule

### hw/rtl/plinorm_mul.sv
// Multiplier stage: registers the selected coefficients and forms the two
// partial products of slope * u from its 32-bit halves. Depends on plinorm_pkg.
module plinorm_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  plinorm_pkg::sel_t in_sel,
  output logic              out_valid,
  input  logic              out_ready,
  output plinorm_pkg::prod_t out_prod
);

  logic              a_v_r;
  plinorm_pkg::sel_t a_r;

  logic signed [64:0] p_hi_full;
  logic [63:0]        p_lo;

  assign in_ready  = !a_v_r || out_ready;
  assign out_valid = a_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ready) begin
      a_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_r <= in_sel;
    end
  end

  // Upper slope word is signed, lower word unsigned; only the upper half
  // of the low product survives the shift by 32.
  assign p_hi_full = $signed(a_r.slope[63:32]) * $signed({1'b0, a_r.u});
  assign p_lo      = a_r.slope[31:0] * a_r.u;

  always_comb begin
    out_prod.p_hi      = p_hi_full[63:0];
    out_prod.lo_top    = p_lo[63:32];
    out_prod.intercept = a_r.intercept;
    out_prod.neg       = a_r.neg;
    out_prod.seg       = a_r.seg;
    out_prod.last      = a_r.last;
  end

endmodule

### hw/rtl/plinorm_fin.sv
// Final stages: sum and saturation, then sign restore and the result register.
// Depends on plinorm_pkg.
module plinorm_fin (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plinorm_pkg::prod_t in_prod,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_deviate,
  output logic [3:0]         out_segment,
  output logic               out_last
);

  logic               b_v_r;
  plinorm_pkg::prod_t b_r;

  logic                          c_v_r;
  logic signed [31:0]            c_z_r;
  logic                          c_neg_r;
  logic [plinorm_pkg::SEG_W-1:0] c_seg_r;
  logic                          c_last_r;

  logic                          d_v_r;
  logic signed [31:0]            d_dev_r;
  logic [plinorm_pkg::SEG_W-1:0] d_seg_r;
  logic                          d_last_r;

  logic               ready_b;
  logic               ready_c;
  logic               ready_d;
  logic signed [65:0] sum;
  logic signed [31:0] z_nxt;
  logic signed [31:0] dev_nxt;

  assign ready_d  = !d_v_r || out_ready;
  assign ready_c  = !c_v_r || ready_d;
  assign ready_b  = !b_v_r || ready_c;
  assign in_ready = ready_b;

  assign sum = 66'(b_r.p_hi) + $signed({34'b0, b_r.lo_top}) + 66'(b_r.intercept);

  always_comb begin
    if (sum > 66'(plinorm_pkg::DEV_MAX)) begin
      z_nxt = plinorm_pkg::DEV_MAX;
    end else if (sum < 66'(plinorm_pkg::DEV_MIN)) begin
      z_nxt = plinorm_pkg::DEV_MIN;
    end else begin
      z_nxt = sum[31:0];
    end
  end

  // Negating the most negative value saturates to the most positive.
  always_comb begin
    if (!c_neg_r) begin
      dev_nxt = c_z_r;
    end else if (c_z_r == plinorm_pkg::DEV_MIN) begin
      dev_nxt = plinorm_pkg::DEV_MAX;
    end else begin
      dev_nxt = -c_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (ready_b) begin
        b_v_r <= in_valid;
      end
      if (ready_c) begin
        c_v_r <= b_v_r;
      end
      if (ready_d) begin
        d_v_r <= c_v_r;
      end
    end
    if (ready_b && in_valid) begin
      b_r <= in_prod;
    end
    if (ready_c && b_v_r) begin
      c_z_r    <= z_nxt;
      c_neg_r  <= b_r.neg;
      c_seg_r  <= b_r.seg;
      c_last_r <= b_r.last;
    end
    if (ready_d && c_v_r) begin
      d_dev_r  <= dev_nxt;
      d_seg_r  <= c_seg_r;
      d_last_r <= c_last_r;
    end
  end

  assign out_valid   = d_v_r;
  assign out_deviate = d_dev_r;
  assign out_segment = 4'(d_seg_r);
  assign out_last    = d_last_r;

  // A folded sample can never give the most negative deviate.
  a_neg_no_min : assert property (@(posedge clk) disable iff (!rst_n)
    (c_v_r && ready_d && c_neg_r) |=> (d_dev_r != plinorm_pkg::DEV_MIN))
    else $error("folded sample produced the most negative deviate");

endmodule

### hw/rtl/piecewise_linear_inverse_normal.sv
// Top level of the piecewise linear inverse normal block.
// Depends on plinorm_pkg, plinorm_front, plinorm_mul and plinorm_fin.
//
// Usage:
//   The in_ stream carries two kinds of word, told apart by in_tuser.
//   A sample word maps an unsigned Q0.32 uniform sample to a signed Q5.26
//   normal deviate and produces one out_ word. A table word writes one
//   intercept/slope pair and produces nothing. A table entry must be
//   written before any sample that selects it.
//   A sample passes five registers (input, multiplier, product, sum and
//   result) before its deviate is offered on out_tdata.
//   Throughput: one word per cycle while the receiver takes every
//   result; every stage takes a new word whenever the stage after it
//   moves on.
//   Reset clears all valid flags; the coefficient table keeps no reset
//   value and is undefined until written.
//   When the receiver stalls, the stages fill one by one and in_tready
//   falls only once every stage holds a word; a waiting result never
//   blocks a word that can still move into an empty stage.
module piecewise_linear_inverse_normal (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] sample, [35:32] entry_index, [67:36] intercept_value,
  // [131:68] slope_value, [135:132] zero
  input  logic [plinorm_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] action
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] deviate, [35:32] segment, [39:36] zero
  output logic [plinorm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tlast
);

  plinorm_pkg::in_item_t in_item;
  plinorm_pkg::sel_t     sel;
  plinorm_pkg::prod_t    prod;

  logic               sel_valid;
  logic               sel_ready;
  logic               prod_valid;
  logic               prod_ready;
  logic signed [31:0] deviate;
  logic [3:0]         segment;
  logic               u_front_busy;

  always_comb begin
    in_item.action      = in_tuser;
    in_item.sample      = in_tdata[31:0];
    in_item.entry_index = in_tdata[35:32];
    in_item.intercept   = in_tdata[67:36];
    in_item.slope       = in_tdata[131:68];
    in_item.last        = in_tlast;
  end

  plinorm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_sel   (sel)
  );

  plinorm_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_sel    (sel),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  plinorm_fin u_fin (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (prod_valid),
    .in_ready    (prod_ready),
    .in_prod     (prod),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_deviate (deviate),
    .out_segment (segment),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'b0, segment, deviate};

  assign u_front_busy = sel_valid || prod_valid || out_tvalid;

  // The input side is held off only when a result is waiting on the receiver.
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // A sample entering an empty pipeline reaches the output without being held by a stall.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser && !u_front_busy) |-> ##5 out_tvalid)
    else $error("sample did not reach the output in five cycles");

endmodule

### tb/testbench.sv
// Self-checking testbench for piecewise_linear_inverse_normal: random and directed words
// through the in_ stream, deviates predicted in place and compared field by field on out_.
// Depends on plinorm_pkg and the piecewise_linear_inverse_normal RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 400;
  localparam logic signed [96:0] WIDE_MAX = plinorm_pkg::DEV_MAX;
  localparam logic signed [96:0] WIDE_MIN = plinorm_pkg::DEV_MIN;

  typedef struct {
    plinorm_pkg::in_item_t item;
    int                    phase;
    bit                    drain_first;
  } input_word_t;

  typedef struct {
    logic signed [31:0] deviate;
    logic [3:0]         segment;
    logic               last;
  } deviate_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [plinorm_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                                in_tuser = plinorm_pkg::ACT_SAMPLE;
  logic                                in_tlast = 1'b0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [plinorm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                                out_tlast;

  input_word_t           input_words[$];
  deviate_t              expected_deviates[$];
  plinorm_pkg::in_item_t cur_word;
  int                    phase = 0;
  int                    fill_phase = 0;
  int                    errors = 0;
  int                    words_accepted = 0;
  int                    table_writes = 0;
  int                    deviates_checked = 0;
  int                    idle_cycles = 0;
  logic [15:0]           segments_hit = '0;

  // Local copy of the coefficient table.
  logic signed [31:0] icpt_tbl  [plinorm_pkg::TABLE_ENTRIES];
  logic signed [63:0] slope_tbl [plinorm_pkg::TABLE_ENTRIES];

  piecewise_linear_inverse_normal u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic int send_idle_pct(int ph);
    case (ph)
      0: return 8;
      1: return 48;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int ph);
    case (ph)
      0: return 48;
      1: return 8;
      default: return 0;
    endcase
  endfunction

  // Updates the table on a write word, or computes the deviate a sample word must give.
  function automatic void predict_deviate(plinorm_pkg::in_item_t w);
    logic [31:0]        u;
    logic               neg;
    int                 lz;
    int                 seg;
    logic signed [96:0] prod;
    logic signed [96:0] sum;
    logic signed [31:0] dev;
    deviate_t           r;
    if (w.action == plinorm_pkg::ACT_WRITE) begin
      if (w.entry_index < plinorm_pkg::TABLE_ENTRIES) begin
        icpt_tbl[w.entry_index] = w.intercept;
        slope_tbl[w.entry_index] = w.slope;
      end
      table_writes++;
      return;
    end
    neg = w.sample[31];
    u = neg ? -w.sample : w.sample;
    lz = 0;
    while (lz < 32 && u[31-lz] == 1'b0) lz++;
    seg = (lz > plinorm_pkg::TABLE_ENTRIES - 1) ? plinorm_pkg::TABLE_ENTRIES - 1 : lz;
    // The arithmetic shift of the full product is the floor of slope * u / 2^32.
    prod = slope_tbl[seg] * $signed({1'b0, u});
    sum = (prod >>> 32) + icpt_tbl[seg];
    if (sum > WIDE_MAX) dev = plinorm_pkg::DEV_MAX;
    else if (sum < WIDE_MIN) dev = plinorm_pkg::DEV_MIN;
    else dev = sum[31:0];
    if (neg) dev = (dev == plinorm_pkg::DEV_MIN) ? plinorm_pkg::DEV_MAX : -dev;
    r.deviate = dev;
    r.segment = 4'(seg);
    r.last = w.last;
    expected_deviates.push_back(r);
  endfunction

  function automatic void add_write(int idx, logic signed [31:0] icpt, logic signed [63:0] slope);
    input_word_t w;
    w.item.action = plinorm_pkg::ACT_WRITE;
    w.item.sample = $urandom;
    w.item.entry_index = 4'(idx);
    w.item.intercept = icpt;
    w.item.slope = slope;
    w.item.last = 1'($urandom_range(0, 1));
    w.phase = fill_phase;
    w.drain_first = 1'b0;
    input_words.push_back(w);
  endfunction

  function automatic void add_sample(logic [31:0] u, logic last, bit drain);
    input_word_t w;
    w.item.action = plinorm_pkg::ACT_SAMPLE;
    w.item.sample = u;
    w.item.entry_index = 4'($urandom);
    w.item.intercept = $urandom;
    w.item.slope = {$urandom, $urandom};
    w.item.last = last;
    w.phase = fill_phase;
    w.drain_first = drain;
    input_words.push_back(w);
  endfunction

  function automatic logic signed [31:0] rand_intercept();
    case ($urandom_range(0, 7))
      0: return plinorm_pkg::DEV_MAX;
      1: return plinorm_pkg::DEV_MIN;
      2, 3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(2, 8);
    endcase
  endfunction

  function automatic logic signed [63:0] rand_slope();
    logic signed [63:0] s;
    s = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: s = 64'sh7FFF_FFFF_FFFF_FFFF;
      1: s = 64'sh8000_0000_0000_0000;
      2, 3: ;
      default: s = s >>> $urandom_range(16, 40);
    endcase
    return s;
  endfunction

  // Driver: a word stays on the bus until it is taken, then the next one may follow.
  always @(posedge clk) begin
    input_word_t nxt;
    bit          launch;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_deviate(cur_word);
        words_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        launch = 1'b0;
        if (input_words.size() > 0) begin
          nxt = input_words[0];
          launch = $urandom_range(0, 99) >= send_idle_pct(nxt.phase);
          if (nxt.drain_first && expected_deviates.size() != 0) launch = 1'b0;
        end
        if (launch) begin
          void'(input_words.pop_front());
          cur_word <= nxt.item;
          in_tdata <= {4'b0, nxt.item.slope, nxt.item.intercept, nxt.item.entry_index,
                       nxt.item.sample};
          in_tuser <= nxt.item.action;
          in_tlast <= nxt.item.last;
          phase <= nxt.phase;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= $urandom_range(0, 99) >= recv_stall_pct(phase);
  end

  // Monitor: each word taken on out_ is matched against the oldest expected deviate.
  always @(posedge clk) begin
    deviate_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_deviates.size() == 0) begin
        $error("unexpected output word: deviate %0d segment %0d",
               $signed(out_tdata[31:0]), out_tdata[35:32]);
        errors++;
      end else begin
        want = expected_deviates.pop_front();
        deviates_checked++;
        segments_hit[want.segment] = 1'b1;
        if (out_tdata[31:0] !== want.deviate) begin
          $error("deviate: expected %0d, got %0d", want.deviate, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[35:32] !== want.segment) begin
          $error("segment: expected %0d, got %0d", want.segment, out_tdata[35:32]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < plinorm_pkg::TABLE_ENTRIES; i++) begin
      icpt_tbl[i] = '0;
      slope_tbl[i] = '0;
    end

    // Fill the whole table first so that no sample ever reads an unwritten entry.
    // Entry 0 drives the sum to the negative limit, entry 1 to the positive one.
    add_write(0, plinorm_pkg::DEV_MIN, 64'sh8000_0000_0000_0000);
    add_write(1, plinorm_pkg::DEV_MAX, 64'sh7FFF_FFFF_FFFF_FFFF);
    for (int i = 2; i < 16; i++) add_write(i, rand_intercept(), rand_slope());

    add_sample(32'h8000_0000, 1'b0, 1'b0);  // one half: reflected, stays in segment 0
    add_sample(32'h4000_0000, 1'b1, 1'b0);
    add_sample(32'h0000_0000, 1'b0, 1'b0);  // zero clamps to the last segment
    add_sample(32'h0000_0001, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);  // reflects to the smallest nonzero value
    add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    add_sample(32'h8000_0001, 1'b0, 1'b0);
    add_sample(32'h0001_0000, 1'b1, 1'b0);
    add_sample(32'hC000_0000, 1'b0, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      logic [31:0] u;
      bit          boundary;
      fill_phase = n * 3 / RANDOM_WORDS;
      boundary = n > 0 && (n * 3 / RANDOM_WORDS) != ((n - 1) * 3 / RANDOM_WORDS);
      if (!boundary && $urandom_range(0, 99) < 12) begin
        add_write($urandom_range(0, 15), rand_intercept(), rand_slope());
      end else begin
        // A random shift spreads the samples over the segments.
        u = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) u = -u;
        // The first word of each later phase waits until the pipeline is empty.
        add_sample(u, 1'($urandom_range(0, 1)), boundary);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (input_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_deviates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words accepted, %0d of them table writes; %0d deviates checked",
             words_accepted, table_writes, deviates_checked);
    $display("segments seen %b, under sender/receiver idling of 8/48, 48/8 and 0/0 percent",
             segments_hit);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
